/* src/u2c_pkg.sv */
// shared types, byte constants and the arrow lookup for the utf-8 to cp866 transcoder
// no dependencies
package u2c_pkg;

    // lead and continuation bytes
    localparam logic [7:0] LEAD_D0    = 8'hD0;
    localparam logic [7:0] LEAD_D1    = 8'hD1;
    localparam logic [7:0] LEAD_C2    = 8'hC2;
    localparam logic [7:0] LEAD_E2    = 8'hE2;
    localparam logic [7:0] ARROW_MID  = 8'h86;
    localparam logic [7:0] YO_UPPER   = 8'h81;
    localparam logic [7:0] YO_LOWER   = 8'h91;
    localparam logic [7:0] CURRENCY   = 8'hA4;

    // code page 866 results
    localparam logic [7:0] CP_YO_UPPER = 8'hF0;
    localparam logic [7:0] CP_YO_LOWER = 8'hF1;
    localparam logic [7:0] CP_CURRENCY = 8'hFD;
    localparam logic [7:0] CP_UNKNOWN  = 8'h3F;
    localparam logic [7:0] LOW_OFFSET  = 8'h10;
    localparam logic [7:0] HIGH_OFFSET = 8'h60;

    // pending lead byte
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_D0   = 3'd1,
        MODE_D1   = 3'd2,
        MODE_C2   = 3'd3,
        MODE_E2   = 3'd4,
        MODE_E286 = 3'd5
    } mode_t;

    // outcome of one input byte
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] res0;
        logic [7:0] res1;
        mode_t      mode_next;
    } map_res_t;

    // third byte of the e2 86 xx arrow sequences
    function automatic logic [7:0] arrow_code(input logic [7:0] b);
        logic [7:0] code;
        case (b)
            8'h90:   code = 8'h1B;
            8'h91:   code = 8'h18;
            8'h92:   code = 8'h1A;
            8'h93:   code = 8'h19;
            8'h96:   code = 8'h1C;
            default: code = CP_UNKNOWN;
        endcase
        return code;
    endfunction

endpackage

/* src/u2c_map.sv */
// byte mapping: pending lead state and one input byte to up to two result bytes
// depends on u2c_pkg
module u2c_map (
    input  u2c_pkg::mode_t    mode,
    input  logic [7:0]        in_byte,
    input  logic              is_last,
    output u2c_pkg::map_res_t res
);
    import u2c_pkg::*;

    // decode against the held lead byte
    always_comb
    begin
        res.count     = 2'd0;
        res.res0      = in_byte;
        res.res1      = in_byte;
        res.mode_next = MODE_IDLE;
        case (mode)
            MODE_D0:
            begin
                if (in_byte == YO_UPPER)
                begin
                    res.count = 2'd1;
                    res.res0  = CP_YO_UPPER;
                end
                else if (in_byte inside {[8'h90:8'hBF]})
                begin
                    res.count = 2'd1;
                    res.res0  = in_byte - LOW_OFFSET;
                end
            end
            MODE_D1:
            begin
                if (in_byte == YO_LOWER)
                begin
                    res.count = 2'd1;
                    res.res0  = CP_YO_LOWER;
                end
                else if (in_byte inside {[8'h80:8'h8F]})
                begin
                    res.count = 2'd1;
                    res.res0  = in_byte + HIGH_OFFSET;
                end
            end
            MODE_C2:
            begin
                res.count = 2'd1;
                res.res0  = (in_byte == CURRENCY) ? CP_CURRENCY : CP_UNKNOWN;
            end
            MODE_E2:
            begin
                if (is_last)
                begin
                    res.count = 2'd2;
                    res.res0  = LEAD_E2;
                end
                else if (in_byte == ARROW_MID)
                begin
                    res.mode_next = MODE_E286;
                end
            end
            MODE_E286:
            begin
                res.count = 2'd1;
                res.res0  = arrow_code(in_byte);
            end
            default:
            begin
                // no lead held: hold a lead byte unless it ends the string
                if (!is_last && in_byte == LEAD_D0)
                    res.mode_next = MODE_D0;
                else if (!is_last && in_byte == LEAD_D1)
                    res.mode_next = MODE_D1;
                else if (!is_last && in_byte == LEAD_C2)
                    res.mode_next = MODE_C2;
                else if (!is_last && in_byte == LEAD_E2)
                    res.mode_next = MODE_E2;
                else
                    res.count = 2'd1;
            end
        endcase
    end

endmodule

/* src/u2c_out_buf.sv */
// two-entry buffer taking one or two results at once, draining one a cycle on m_tready
// depends on u2c_pkg
module u2c_out_buf (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_count,
    input  logic       push_en,
    input  logic [7:0] push_res0,
    input  logic [7:0] push_res1,
    output logic       can_push,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic       m_tlast
);
    import u2c_pkg::*;

    logic [8:0] data_reg [2];
    logic [8:0] data_next [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] base;
    logic       pop;

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = data_reg[0][7:0];
    assign m_tlast  = data_reg[0][8];
    assign pop      = m_tvalid && m_tready;
    assign base     = count_reg - {1'b0, pop};
    assign can_push = ({1'b0, base} + {1'b0, push_count}) <= 3'd2;

    // shift out the popped entry, then append new results
    always_comb
    begin
        data_next[0] = (pop && count_reg == 2'd2) ? data_reg[1] : data_reg[0];
        data_next[1] = data_reg[1];
        count_next   = base;
        if (push_en)
        begin
            count_next = base + push_count;
            case (push_count)
                2'd1:
                    data_next[base[0]] = {1'b1, push_res0};
                2'd2:
                begin
                    data_next[0] = {1'b0, push_res0};
                    data_next[1] = {1'b1, push_res1};
                end
                default:
                    count_next = base;
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        data_reg[0] <= data_next[0];
        data_reg[1] <= data_next[1];
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

endmodule

/* src/utf8_to_cp866_transcoder_unit.sv */
// Top level of the utf-8 to code page 866 transcoder.
// Depends on u2c_pkg, u2c_map and u2c_out_buf.
//
// Usage:
//   s_* takes one utf-8 byte per transfer in s_tdata, with s_tlast set on the
//   last byte of a string. m_* gives code page 866 bytes; m_tlast is set on
//   the last result that an input byte produced.
//   An input byte yields zero, one or two results. Lead bytes D0, D1, C2 and
//   E2 (and E2 86) are held until the following byte arrives.
// Path: an accepted byte is held in the input register, is mapped and
//   written to the result buffer, and its first result is offered from
//   that buffer.
// Throughput: one byte per cycle while m_tready is high; a byte with two
//   results may wait in the input register until the single output port
//   of the two-entry result buffer has drained room for both.
// Reset: rst_n clears the pending lead byte and empties both registers.
// Stall: while m_tready is low the result buffer fills, then the input
//   register holds and s_tready drops; nothing is lost or repeated.
module utf8_to_cp866_transcoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic       m_tlast
);
    import u2c_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    mode_t      mode_reg;
    mode_t      mode_next;
    map_res_t   map_res;
    logic       can_push;
    logic       advance;

    // mapping of the registered byte
    u2c_map u_map (
        .mode    (mode_reg),
        .in_byte (in_byte_reg),
        .is_last (in_last_reg),
        .res     (map_res)
    );

    // result buffer
    u2c_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (map_res.count),
        .push_en    (advance),
        .push_res0  (map_res.res0),
        .push_res1  (map_res.res1),
        .can_push   (can_push),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // input register moves on once its results fit
    assign advance       = in_valid_reg && can_push;
    assign s_tready      = !in_valid_reg || advance;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !advance);
    assign mode_next     = advance ? map_res.mode_next : mode_reg;

    // input payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_IDLE;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            mode_reg     <= mode_next;
        end
    end

endmodule
